FILE: sv/dtwbt_pkg.sv
// ----------------------------------------------------------------------------
// dtwbt_pkg
// Shared types, codes and sizes for the warping path backtracker.
// ----------------------------------------------------------------------------
package dtwbt_pkg;

  // default sizes of the stores
  localparam int MAX_ROWS_DEF     = 256;
  localparam int MAX_COLS_DEF     = 256;
  localparam int TABLE_ROWS_DEF   = 16;
  localparam int MAX_PATTERNS_DEF = 8;

  // fixed field widths
  localparam int POS_W  = 8;
  localparam int PCNT_W = 14;
  localparam int ECNT_W = 10;
  localparam int SCNT_W = 10;
  localparam int CFG_W  = 5;

  localparam logic [PCNT_W-1:0] PCNT_MAX = '1;
  localparam logic [ECNT_W-1:0] ECNT_MAX = '1;
  localparam logic [SCNT_W-1:0] SCNT_MAX = '1;

  localparam logic [CFG_W-1:0] ROWS_RESET = 5'd1;

  // operation codes
  localparam logic [1:0] OP_WRITE_PATTERN = 2'd0;
  localparam logic [1:0] OP_WRITE_CELL    = 2'd1;
  localparam logic [1:0] OP_START         = 2'd2;
  localparam logic [1:0] OP_ADVANCE       = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_START  = 3'd0;
  localparam logic [2:0] KIND_STEP   = 3'd1;
  localparam logic [2:0] KIND_POINT  = 3'd2;
  localparam logic [2:0] KIND_END    = 3'd3;
  localparam logic [2:0] KIND_ORIGIN = 3'd4;
  localparam logic [2:0] KIND_NOSTEP = 3'd5;
  localparam logic [2:0] KIND_ERROR  = 3'd6;

  // walk status: idle, walking, or the kind that ended the walk
  localparam logic [2:0] WALK_IDLE   = 3'd0;
  localparam logic [2:0] WALK_ACTIVE = 3'd1;

  typedef struct packed {
    logic [1:0]       operation;
    logic [3:0]       table_row;
    logic [2:0]       pattern_id;
    logic [2:0]       delta_row;
    logic [2:0]       delta_col;
    logic [POS_W-1:0] cell_row;
    logic [POS_W-1:0] cell_col;
    logic [2:0]       cell_step;
    logic             cell_none;
    logic [POS_W-1:0] last_row;
    logic [POS_W-1:0] start_col;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [2:0]        step;
    logic [PCNT_W-1:0] point_count;
    logic [ECNT_W-1:0] endpoint_count;
    logic [SCNT_W-1:0] step_count;
    logic              last;
  } out_item_t;

  // one row of the step-pattern table
  typedef struct packed {
    logic [2:0] pid;
    logic [2:0] dr;
    logic [2:0] dc;
  } pat_entry_t;

  // one cell of the step-choice matrix
  typedef struct packed {
    logic       none;
    logic [2:0] step;
  } cell_t;

  // status from the shared delta unit
  typedef struct packed {
    logic             match;
    logic             under;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } delta_res_t;

endpackage

FILE: sv/dtw_step_pattern_backtrack_unit.sv
// ----------------------------------------------------------------------------
// dtw_step_pattern_backtrack_unit
// Warping path backtracker: pattern table and step matrix loads, start of a
// walk and one step of the walk per advance transaction.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                 payload
//   in        input      in_valid / in_stall       in_data  (in_item_t)
//   out       output     out_valid / out_stall     out_data (out_item_t)
//   cfg       input      cfg_write                 cfg_wdata (row count)
//
// Loads are written while the sequencer stays idle; output stalls hold it.
// A start goes out through S_RESULT. An advance, np the scanned table rows:
// one pass over the table checks the step, a second pass walks it backward to
// emit points, both through the one delta unit; the matrix read is registered.
// Reset is synchronous; the matrix and the table are not cleared.
// in_stall is high whenever the sequencer is busy.
// ----------------------------------------------------------------------------
module dtw_step_pattern_backtrack_unit #(
  parameter int MAX_ROWS     = dtwbt_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS     = dtwbt_pkg::MAX_COLS_DEF,
  parameter int TABLE_ROWS   = dtwbt_pkg::TABLE_ROWS_DEF,
  parameter int MAX_PATTERNS = dtwbt_pkg::MAX_PATTERNS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  dtwbt_pkg::in_item_t         in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output dtwbt_pkg::out_item_t        out_data,
  input  logic                        cfg_write,
  input  logic [dtwbt_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int MA_W  = $clog2(MAX_ROWS * MAX_COLS);
  localparam int TR_W  = $clog2(TABLE_ROWS);
  localparam int CNT_W = $clog2(TABLE_ROWS + 1);
  localparam int POS_W = dtwbt_pkg::POS_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RESULT,
    S_CHECK,
    S_CELL,
    S_SCAN,
    S_STEP_OUT,
    S_EMIT,
    S_END_OUT
  } state_t;

  state_t state;

  // stores
  dtwbt_pkg::cell_t      matrix [MAX_ROWS * MAX_COLS];
  dtwbt_pkg::pat_entry_t pat_table [TABLE_ROWS];
  dtwbt_pkg::cell_t      cell_q;

  // walk state
  logic [dtwbt_pkg::CFG_W-1:0]  row_count;
  logic [POS_W-1:0]             cur_row;
  logic [POS_W-1:0]             cur_col;
  logic [dtwbt_pkg::PCNT_W-1:0] points;
  logic [dtwbt_pkg::ECNT_W-1:0] endpoints;
  logic [dtwbt_pkg::SCNT_W-1:0] steps;
  logic [2:0]                   walk_status;

  // sequencer working registers
  logic [2:0]      res_kind;
  logic            res_set_status;
  logic [2:0]      step_sel;
  logic [CNT_W-1:0] r;
  logic [CNT_W-1:0] ns;
  logic [TR_W-1:0] first_idx;

  logic                  accept;
  logic                  out_free;
  logic [CNT_W-1:0]      np;
  logic [TR_W-1:0]       tbl_addr;
  logic [MA_W-1:0]       wr_addr;
  logic [MA_W-1:0]       rd_addr;
  logic                  wr_in_range;
  logic [dtwbt_pkg::PCNT_W:0] points_sum;
  dtwbt_pkg::pat_entry_t tbl_entry;
  dtwbt_pkg::delta_res_t du;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // scanned table rows, limited to the table depth
  assign np = (32'(row_count) > TABLE_ROWS) ? CNT_W'(TABLE_ROWS) : CNT_W'(row_count);

  // matrix addresses, row major with a stride of the column count
  assign wr_addr = MA_W'(MA_W'(in_data.cell_row) * MA_W'(MAX_COLS) + MA_W'(in_data.cell_col));
  assign rd_addr = MA_W'(MA_W'(cur_row) * MA_W'(MAX_COLS) + MA_W'(cur_col));
  assign wr_in_range = (32'(in_data.cell_row) < MAX_ROWS) && (32'(in_data.cell_col) < MAX_COLS);

  // table read port, steered by the sequencer
  assign tbl_addr  = (state == S_END_OUT) ? first_idx : TR_W'(r);
  assign tbl_entry = pat_table[tbl_addr];

  assign points_sum = (dtwbt_pkg::PCNT_W + 1)'(points) + (dtwbt_pkg::PCNT_W + 1)'(ns);

  dtwbt_delta_unit u_delta (
    .cur_row (cur_row),
    .cur_col (cur_col),
    .step    (step_sel),
    .entry   (tbl_entry),
    .res     (du)
  );

  // step matrix, one write and one registered read port
  always_ff @(posedge clk) begin
    if (accept && (in_data.operation == dtwbt_pkg::OP_WRITE_CELL) && wr_in_range) begin
      matrix[wr_addr] <= '{none: in_data.cell_none, step: in_data.cell_step};
    end
    cell_q <= matrix[rd_addr];
  end

  // pattern table writes
  always_ff @(posedge clk) begin
    if (accept && (in_data.operation == dtwbt_pkg::OP_WRITE_PATTERN) &&
        (32'(in_data.table_row) < TABLE_ROWS)) begin
      pat_table[TR_W'(in_data.table_row)] <= '{pid: in_data.pattern_id,
                                               dr:  in_data.delta_row,
                                               dc:  in_data.delta_col};
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      row_count      <= dtwbt_pkg::ROWS_RESET;
      cur_row        <= '0;
      cur_col        <= '0;
      points         <= '0;
      endpoints      <= '0;
      steps          <= '0;
      walk_status    <= dtwbt_pkg::WALK_IDLE;
      res_kind       <= dtwbt_pkg::KIND_ERROR;
      res_set_status <= 1'b0;
    end else begin
      if (cfg_write) begin
        row_count <= cfg_wdata;
      end

      // a taken result frees the output register
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_data.operation)
              dtwbt_pkg::OP_START: begin
                cur_row        <= in_data.last_row;
                cur_col        <= in_data.start_col;
                points         <= dtwbt_pkg::PCNT_W'(1);
                endpoints      <= dtwbt_pkg::ECNT_W'(1);
                steps          <= '0;
                walk_status    <= dtwbt_pkg::WALK_ACTIVE;
                res_kind       <= dtwbt_pkg::KIND_START;
                res_set_status <= 1'b0;
                state          <= S_RESULT;
              end
              dtwbt_pkg::OP_ADVANCE: begin
                state <= S_CHECK;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        // single result transaction that closes the item
        S_RESULT: begin
          if (out_free) begin
            out_valid               <= 1'b1;
            out_data.kind           <= res_kind;
            out_data.row            <= cur_row;
            out_data.col            <= cur_col;
            out_data.step           <= '0;
            out_data.last           <= 1'b1;
            if (res_kind == dtwbt_pkg::KIND_START) begin
              out_data.point_count    <= '0;
              out_data.endpoint_count <= '0;
              out_data.step_count     <= '0;
            end else begin
              out_data.point_count    <= points;
              out_data.endpoint_count <= endpoints;
              out_data.step_count     <= steps;
            end
            if (res_set_status) begin
              walk_status <= res_kind;
            end
            state <= S_IDLE;
          end
        end

        // walk status and position checks, matrix read issued here
        S_CHECK: begin
          res_set_status <= 1'b1;
          if (walk_status == dtwbt_pkg::WALK_IDLE) begin
            res_kind       <= dtwbt_pkg::KIND_ERROR;
            res_set_status <= 1'b0;
            state          <= S_RESULT;
          end else if (walk_status != dtwbt_pkg::WALK_ACTIVE) begin
            res_kind       <= walk_status;
            res_set_status <= 1'b0;
            state          <= S_RESULT;
          end else if ((cur_row == '0) && (cur_col == '0)) begin
            res_kind <= dtwbt_pkg::KIND_ORIGIN;
            state    <= S_RESULT;
          end else if ((32'(cur_row) >= MAX_ROWS) || (32'(cur_col) >= MAX_COLS)) begin
            res_kind <= dtwbt_pkg::KIND_ERROR;
            state    <= S_RESULT;
          end else begin
            state <= S_CELL;
          end
        end

        // decode the cell just read
        S_CELL: begin
          if (cell_q.none) begin
            res_kind <= dtwbt_pkg::KIND_NOSTEP;
            state    <= S_RESULT;
          end else if (32'(cell_q.step) >= MAX_PATTERNS) begin
            res_kind <= dtwbt_pkg::KIND_ERROR;
            state    <= S_RESULT;
          end else begin
            step_sel <= cell_q.step;
            r        <= '0;
            ns       <= '0;
            state    <= S_SCAN;
          end
        end

        // forward pass: count matching rows, catch moves below zero
        S_SCAN: begin
          if (r == np) begin
            if (ns == '0) begin
              res_kind <= dtwbt_pkg::KIND_ERROR;
              state    <= S_RESULT;
            end else begin
              state <= S_STEP_OUT;
            end
          end else if (du.match && du.under) begin
            res_kind <= dtwbt_pkg::KIND_ERROR;
            state    <= S_RESULT;
          end else begin
            if (du.match) begin
              if (ns == '0) begin
                first_idx <= tbl_addr;
              end
              ns <= ns + CNT_W'(1);
            end
            r <= r + CNT_W'(1);
          end
        end

        // step id transaction
        S_STEP_OUT: begin
          if (out_free) begin
            out_valid               <= 1'b1;
            out_data.kind           <= dtwbt_pkg::KIND_STEP;
            out_data.row            <= cur_row;
            out_data.col            <= cur_col;
            out_data.step           <= step_sel;
            out_data.point_count    <= '0;
            out_data.endpoint_count <= '0;
            out_data.step_count     <= '0;
            out_data.last           <= 1'b0;
            r                       <= np - CNT_W'(1);
            state                   <= S_EMIT;
          end
        end

        // backward pass: one path point per matching row
        S_EMIT: begin
          if (!du.match || out_free) begin
            if (du.match) begin
              out_valid               <= 1'b1;
              out_data.kind           <= dtwbt_pkg::KIND_POINT;
              out_data.row            <= du.row;
              out_data.col            <= du.col;
              out_data.step           <= '0;
              out_data.point_count    <= '0;
              out_data.endpoint_count <= '0;
              out_data.step_count     <= '0;
              out_data.last           <= 1'b0;
            end
            if (r == '0) begin
              state <= S_END_OUT;
            end else begin
              r <= r - CNT_W'(1);
            end
          end
        end

        // move to the point of the first matching table row and close the step
        S_END_OUT: begin
          if (out_free) begin
            out_valid               <= 1'b1;
            out_data.kind           <= dtwbt_pkg::KIND_END;
            out_data.row            <= du.row;
            out_data.col            <= du.col;
            out_data.step           <= '0;
            out_data.point_count    <= '0;
            out_data.endpoint_count <= '0;
            out_data.step_count     <= '0;
            out_data.last           <= 1'b1;
            cur_row                 <= du.row;
            cur_col                 <= du.col;
            if (steps != dtwbt_pkg::SCNT_MAX) begin
              steps <= steps + dtwbt_pkg::SCNT_W'(1);
            end
            if (endpoints != dtwbt_pkg::ECNT_MAX) begin
              endpoints <= endpoints + dtwbt_pkg::ECNT_W'(1);
            end
            if (points_sum > (dtwbt_pkg::PCNT_W + 1)'(dtwbt_pkg::PCNT_MAX)) begin
              points <= dtwbt_pkg::PCNT_MAX;
            end else begin
              points <= points_sum[dtwbt_pkg::PCNT_W-1:0];
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/dtwbt_delta_unit.sv
// ----------------------------------------------------------------------------
// dtwbt_delta_unit
// Shared compare and subtract unit: tests one table row against the chosen
// step and forms the point it reaches from the current position.
// ----------------------------------------------------------------------------
module dtwbt_delta_unit (
  input  logic [dtwbt_pkg::POS_W-1:0] cur_row,
  input  logic [dtwbt_pkg::POS_W-1:0] cur_col,
  input  logic [2:0]                  step,
  input  dtwbt_pkg::pat_entry_t       entry,
  output dtwbt_pkg::delta_res_t       res
);

  logic [dtwbt_pkg::POS_W-1:0] dr_ext;
  logic [dtwbt_pkg::POS_W-1:0] dc_ext;

  assign dr_ext = dtwbt_pkg::POS_W'(entry.dr);
  assign dc_ext = dtwbt_pkg::POS_W'(entry.dc);

  // row belongs to the step and is not the null delta
  always_comb begin
    res.match = (entry.pid == step) && ((entry.dr != 3'd0) || (entry.dc != 3'd0));
    res.under = (dr_ext > cur_row) || (dc_ext > cur_col);
    res.row   = cur_row - dr_ext;
    res.col   = cur_col - dc_ext;
  end

endmodule

FILE: dv/dtw_step_pattern_backtrack_unit_test.sv
// ----------------------------------------------------------------------------
// dtw_step_pattern_backtrack_unit_test
// Self-checking bench for the warping path backtracker. Pattern table and
// matrix loads, walk starts and advances are queued by a stimulus process,
// driven over the valid/stall input channel, and every output transaction is
// compared field by field against an in-bench model of the walk. The row
// count register is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module dtw_step_pattern_backtrack_unit_test;

  // two copies of the walk state: one runs ahead while stimulus is built,
  // one follows the transactions the block accepts
  localparam int GEN = 0;
  localparam int CHK = 1;
  localparam int NTAB = dtwbt_pkg::TABLE_ROWS_DEF;
  localparam int NCELLS = dtwbt_pkg::MAX_ROWS_DEF * dtwbt_pkg::MAX_COLS_DEF;
  localparam int POS_W = dtwbt_pkg::POS_W;

  // octal digits: pattern id, row delta, column delta
  localparam logic [8:0] START_TABLE [16] = '{
    9'o011, 9'o110, 9'o201, 9'o300, 9'o421, 9'o410, 9'o577, 9'o600,
    9'o612, 9'o621, 9'o611, 9'o730, 9'o703, 9'o202, 9'o120, 9'o022
  };

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  dtwbt_pkg::in_item_t         in_data = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  dtwbt_pkg::out_item_t        out_data;
  logic                        cfg_write = 1'b0;
  logic [dtwbt_pkg::CFG_W-1:0] cfg_wdata = '0;

  // model state, one slot per copy
  logic [3:0]                   step_mem [2][NCELLS];
  dtwbt_pkg::pat_entry_t        pat_mem [2][NTAB];
  logic [POS_W-1:0]             pos_row [2];
  logic [POS_W-1:0]             pos_col [2];
  logic [dtwbt_pkg::PCNT_W-1:0] pts [2];
  logic [dtwbt_pkg::ECNT_W-1:0] ends_n [2];
  logic [dtwbt_pkg::SCNT_W-1:0] steps_n [2];
  logic [2:0]                   status [2];
  logic [dtwbt_pkg::CFG_W-1:0]  rows_cfg = dtwbt_pkg::ROWS_RESET;
  bit                           cell_written [NCELLS];

  dtwbt_pkg::out_item_t scratch [$];
  dtwbt_pkg::in_item_t  queued_items [$];
  dtwbt_pkg::out_item_t results_due [$];

  int items_queued = 0;
  int items_accepted = 0;
  int fail_count = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int idle_odds = 0;
  int drain_pause_at = -1;
  int long_hold_from = 32'h7fffffff;
  int hold_left = 0;
  bit hold_fired = 1'b0;

  dtw_step_pattern_backtrack_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    for (int v = 0; v < 2; v++) begin
      pos_row[v] = '0;
      pos_col[v] = '0;
      pts[v] = '0;
      ends_n[v] = '0;
      steps_n[v] = '0;
      status[v] = dtwbt_pkg::WALK_IDLE;
    end
  end

  // ---------------------------------------------------------------------------
  // walk model
  // ---------------------------------------------------------------------------

  function automatic dtwbt_pkg::out_item_t walk_result(int v, logic [2:0] kind,
                                                       logic [POS_W-1:0] r,
                                                       logic [POS_W-1:0] c, logic [2:0] s,
                                                       bit with_counts, bit last);
    dtwbt_pkg::out_item_t o;
    o.kind           = kind;
    o.row            = r;
    o.col            = c;
    o.step           = s;
    o.point_count    = with_counts ? pts[v] : '0;
    o.endpoint_count = with_counts ? ends_n[v] : '0;
    o.step_count     = with_counts ? steps_n[v] : '0;
    o.last           = last;
    return o;
  endfunction

  function automatic void end_walk(int v, logic [2:0] kind);
    status[v] = kind;
    scratch.push_back(walk_result(v, kind, pos_row[v], pos_col[v], 3'd0, 1'b1, 1'b1));
  endfunction

  // works out the results of one transaction into scratch
  function automatic void backtrack_predict(int v, dtwbt_pkg::in_item_t it);
    int                    hits [$];
    int                    np;
    int                    t;
    dtwbt_pkg::cell_t      cl;
    dtwbt_pkg::pat_entry_t e;
    bit                    under;
    scratch.delete();
    case (it.operation)
      dtwbt_pkg::OP_WRITE_PATTERN: begin
        pat_mem[v][it.table_row] = {it.pattern_id, it.delta_row, it.delta_col};
      end
      dtwbt_pkg::OP_WRITE_CELL: begin
        step_mem[v][{it.cell_row, it.cell_col}] = {it.cell_none, it.cell_step};
      end
      dtwbt_pkg::OP_START: begin
        pos_row[v] = it.last_row;
        pos_col[v] = it.start_col;
        pts[v] = 1;
        ends_n[v] = 1;
        steps_n[v] = 0;
        status[v] = dtwbt_pkg::WALK_ACTIVE;
        scratch.push_back(walk_result(v, dtwbt_pkg::KIND_START, pos_row[v], pos_col[v],
                                      3'd0, 1'b0, 1'b1));
      end
      default: begin
        if (status[v] == dtwbt_pkg::WALK_IDLE) begin
          scratch.push_back(walk_result(v, dtwbt_pkg::KIND_ERROR, pos_row[v], pos_col[v],
                                        3'd0, 1'b1, 1'b1));
        end else if (status[v] != dtwbt_pkg::WALK_ACTIVE) begin
          // walk already over: repeat its end transaction
          scratch.push_back(walk_result(v, status[v], pos_row[v], pos_col[v], 3'd0,
                                        1'b1, 1'b1));
        end else if (pos_row[v] == 0 && pos_col[v] == 0) begin
          end_walk(v, dtwbt_pkg::KIND_ORIGIN);
        end else begin
          cl = step_mem[v][{pos_row[v], pos_col[v]}];
          np = (rows_cfg > NTAB) ? NTAB : int'(rows_cfg);
          under = 1'b0;
          for (int r = 0; r < np; r++) begin
            e = pat_mem[v][r];
            if (e.pid == cl.step && (e.dr != 0 || e.dc != 0)) begin
              if (e.dr > pos_row[v] || e.dc > pos_col[v]) under = 1'b1;
              else hits.push_back(r);
            end
          end
          if (cl.none) begin
            end_walk(v, dtwbt_pkg::KIND_NOSTEP);
          end else if (int'(cl.step) >= dtwbt_pkg::MAX_PATTERNS_DEF || under ||
                       hits.size() == 0) begin
            end_walk(v, dtwbt_pkg::KIND_ERROR);
          end else begin
            scratch.push_back(walk_result(v, dtwbt_pkg::KIND_STEP, pos_row[v], pos_col[v],
                                          cl.step, 1'b0, 1'b0));
            // points go out in reverse table order
            for (int k = hits.size() - 1; k >= 0; k--) begin
              e = pat_mem[v][hits[k]];
              scratch.push_back(walk_result(v, dtwbt_pkg::KIND_POINT, pos_row[v] - e.dr,
                                            pos_col[v] - e.dc, 3'd0, 1'b0, 1'b0));
            end
            e = pat_mem[v][hits[0]];
            pos_row[v] = pos_row[v] - e.dr;
            pos_col[v] = pos_col[v] - e.dc;
            scratch.push_back(walk_result(v, dtwbt_pkg::KIND_END, pos_row[v], pos_col[v],
                                          3'd0, 1'b0, 1'b1));
            if (steps_n[v] != dtwbt_pkg::SCNT_MAX) steps_n[v] = steps_n[v] + 1'b1;
            if (ends_n[v] != dtwbt_pkg::ECNT_MAX) ends_n[v] = ends_n[v] + 1'b1;
            t = int'(pts[v]) + hits.size();
            pts[v] = (t > int'(dtwbt_pkg::PCNT_MAX)) ? dtwbt_pkg::PCNT_MAX :
                                                       dtwbt_pkg::PCNT_W'(t);
          end
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  // every field random; callers overwrite the ones that matter
  function automatic dtwbt_pkg::in_item_t raw_item();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(dtwbt_pkg::in_item_t)-1:0];
  endfunction

  function automatic void queue_item(dtwbt_pkg::in_item_t it);
    backtrack_predict(GEN, it);
    queued_items.push_back(it);
    items_queued++;
  endfunction

  function automatic void queue_pattern(logic [3:0] r, logic [2:0] pid, logic [2:0] dr,
                                        logic [2:0] dc);
    dtwbt_pkg::in_item_t it;
    it = raw_item();
    it.operation  = dtwbt_pkg::OP_WRITE_PATTERN;
    it.table_row  = r;
    it.pattern_id = pid;
    it.delta_row  = dr;
    it.delta_col  = dc;
    queue_item(it);
  endfunction

  function automatic void queue_cell(logic [7:0] r, logic [7:0] c, logic [2:0] s, logic none);
    dtwbt_pkg::in_item_t it;
    it = raw_item();
    it.operation = dtwbt_pkg::OP_WRITE_CELL;
    it.cell_row  = r;
    it.cell_col  = c;
    it.cell_step = s;
    it.cell_none = none;
    cell_written[{r, c}] = 1'b1;
    queue_item(it);
  endfunction

  function automatic void queue_start(logic [7:0] r, logic [7:0] c);
    dtwbt_pkg::in_item_t it;
    it = raw_item();
    it.operation = dtwbt_pkg::OP_START;
    it.last_row  = r;
    it.start_col = c;
    queue_item(it);
  endfunction

  // the cell under the walk gets loaded first if it never was
  function automatic void queue_advance();
    dtwbt_pkg::in_item_t it;
    if (status[GEN] == dtwbt_pkg::WALK_ACTIVE && {pos_row[GEN], pos_col[GEN]} != 16'd0 &&
        !cell_written[{pos_row[GEN], pos_col[GEN]}])
      queue_cell(pos_row[GEN], pos_col[GEN], 3'($urandom_range(0, 7)),
                 $urandom_range(0, 11) == 0);
    it = raw_item();
    it.operation = dtwbt_pkg::OP_ADVANCE;
    queue_item(it);
  endfunction

  // small deltas most of the time so walks can get somewhere
  function automatic logic [2:0] rand_delta();
    return ($urandom_range(0, 3) != 0) ? 3'($urandom_range(0, 2)) : 3'($urandom_range(0, 7));
  endfunction

  // about n transactions, mostly start/advance sequences, with loads and
  // stray transactions mixed in
  function automatic void random_walks(int n);
    int pick;
    int stop_at;
    stop_at = items_queued + n;
    repeat (4) queue_pattern(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                             rand_delta(), rand_delta());
    while (items_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      if ((status[GEN] != dtwbt_pkg::WALK_ACTIVE) ? (pick < 85) : (pick < 5)) begin
        if ($urandom_range(0, 4) == 0)
          queue_start(8'($urandom), 8'($urandom));
        else
          queue_start(8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)));
      end else if (pick < 10) begin
        queue_cell(8'($urandom), 8'($urandom), 3'($urandom_range(0, 7)), 1'($urandom));
      end else if (pick < 14) begin
        queue_pattern(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                      rand_delta(), rand_delta());
      end else begin
        queue_advance();
      end
    end
  endfunction

  // wait for the block to go quiet, then write the row count
  task automatic settle_and_config(logic [dtwbt_pkg::CFG_W-1:0] n);
    while (queued_items.size() != 0 || in_valid || results_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_write <= 1'b0;
    rows_cfg = n;
  endtask

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    logic [8:0] e;
    logic [5:0] d;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    idle_odds <= 4;

    for (int r = 0; r < NTAB; r++) begin
      e = START_TABLE[r];
      queue_pattern(4'(r), e[8:6], e[5:3], e[2:0]);
    end

    // one scanned table row: advance while idle, origin and its repeat
    queue_advance();
    queue_start(8'd0, 8'd0);
    queue_advance();
    queue_advance();
    // one step, then a no-step cell and its repeat
    queue_cell(8'd3, 8'd2, 3'd0, 1'b0);
    queue_cell(8'd2, 8'd1, 3'd5, 1'b1);
    queue_start(8'd3, 8'd2);
    queue_advance();
    queue_advance();
    queue_advance();
    // delta below zero at the last row, column zero
    queue_cell(8'd255, 8'd0, 3'd0, 1'b0);
    queue_start(8'd255, 8'd0);
    queue_advance();
    // pattern not among the scanned rows
    queue_cell(8'd255, 8'd255, 3'd1, 1'b0);
    queue_start(8'd255, 8'd255);
    queue_advance();
    queue_cell(8'd0, 8'd255, 3'd7, 1'b1);
    queue_start(8'd0, 8'd255);
    queue_advance();

    // full table: two-point pattern, null-only pattern, deep underflow
    settle_and_config(5'd16);
    queue_cell(8'd5, 8'd5, 3'd4, 1'b0);
    queue_cell(8'd3, 8'd4, 3'd3, 1'b0);
    queue_start(8'd5, 8'd5);
    queue_advance();
    queue_advance();
    queue_cell(8'd6, 8'd6, 3'd5, 1'b0);
    queue_start(8'd6, 8'd6);
    queue_advance();
    queue_cell(8'd9, 8'd9, 3'd6, 1'b0);
    queue_cell(8'd8, 8'd7, 3'd1, 1'b0);
    queue_start(8'd9, 8'd9);
    queue_advance();
    queue_advance();

    // zero rows scanned
    settle_and_config(5'd0);
    queue_cell(8'd4, 8'd4, 3'd0, 1'b0);
    queue_start(8'd4, 8'd4);
    queue_advance();

    // row count past the table size
    settle_and_config(5'd31);
    queue_start(8'd9, 8'd9);
    queue_advance();

    // one pattern over every table row: the longest advance
    settle_and_config(5'd16);
    for (int r = 0; r < NTAB; r++) begin
      d = 6'(r + 1);
      queue_pattern(4'(r), 3'd7, d[5:3], d[2:0]);
    end
    queue_cell(8'd20, 8'd20, 3'd7, 1'b0);
    queue_start(8'd20, 8'd20);
    queue_advance();
    queue_advance();

    // random phases
    settle_and_config(5'd16);
    long_hold_from <= items_accepted + 15;
    idle_odds <= 3;
    random_walks(40);

    settle_and_config(5'd1);
    idle_odds <= 6;
    random_walks(25);

    settle_and_config(5'd8);
    drain_pause_at <= items_accepted + 20;
    idle_odds <= 2;
    random_walks(40);

    settle_and_config(5'd31);
    idle_odds <= 10;
    random_walks(35);

    settle_and_config(5'd0);
    random_walks(15);

    settle_and_config(5'd12);
    idle_odds <= 5;
    random_walks(40);

    // closing stretch without idling
    settle_and_config(5'd16);
    idle_odds <= 0;
    random_walks(41);

    while (queued_items.size() != 0 || in_valid || results_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // run limit
  initial begin
    #8000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // input driver
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic                take;
    logic                nv;
    bit                  wait_drain;
    dtwbt_pkg::in_item_t nd;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      take = in_valid && !in_stall;
      nv = in_valid && !take;
      nd = in_data;
      if (take) begin
        backtrack_predict(CHK, in_data);
        foreach (scratch[i]) results_due.push_back(scratch[i]);
        items_accepted++;
        if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
          send_gap = $urandom_range(1, 14);
      end
      // next transaction unless idling or waiting for all results
      if (!nv) begin
        wait_drain = (items_accepted == drain_pause_at) && (results_due.size() != 0);
        if (send_gap > 0) begin
          send_gap--;
        end else if (!wait_drain && queued_items.size() != 0) begin
          nd = queued_items.pop_front();
          nv = 1'b1;
        end
      end
      in_valid <= nv;
      in_data <= nd;
    end
  end

  // long output hold-off, once
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_fired && items_accepted >= long_hold_from) begin
      hold_fired <= 1'b1;
      hold_left <= 300;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // output monitor
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    dtwbt_pkg::out_item_t want;
    logic                 ns;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual %h", $time, out_data);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          check_field("kind", want.kind, out_data.kind);
          check_field("row", want.row, out_data.row);
          check_field("col", want.col, out_data.col);
          check_field("step", want.step, out_data.step);
          check_field("point_count", want.point_count, out_data.point_count);
          check_field("endpoint_count", want.endpoint_count, out_data.endpoint_count);
          check_field("step_count", want.step_count, out_data.step_count);
          check_field("last", want.last, out_data.last);
        end
      end
      // random stall bursts, and the long hold-off
      if (hold_left > 0) begin
        ns = 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        ns = 1'b1;
      end else if (idle_odds != 0 && $urandom_range(0, 2 * idle_odds) == 0) begin
        recv_gap = $urandom_range(0, 13);
        ns = 1'b1;
      end else begin
        ns = 1'b0;
      end
      out_stall <= ns;
    end
  end

endmodule
